### sv/plucked_string_waveguide_macros.svh
// Assertion shorthands for the string voice
`ifndef PLUCKED_STRING_WAVEGUIDE_MACROS_SVH
`define PLUCKED_STRING_WAVEGUIDE_MACROS_SVH
`ifndef SYNTHESIS
`define PSWG_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("string voice check failed");
`define PSWG_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("string voice check failed");
`else
`define PSWG_ASSERT_IMP(name, ante, cons)
`define PSWG_ASSERT_NXT(name, ante, cons)
`endif
`endif

### sv/pswg_pkg.sv
package pswg_pkg;

  localparam int PSWG_MAX_LOOP     = 1024;
  localparam int PSWG_MAX_ADVANCES = 8;

  localparam int SAMPLE_W = 16;
  localparam int CFG_W    = 18;
  localparam int LEN_W    = 11;
  localparam int INC_W    = 18;
  localparam int RATE_W   = 16;
  localparam int IDX_W    = 10;
  localparam int FRAC_W   = 16;

  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_STEP    = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  localparam logic [1:0] REG_LOOP_LENGTH    = 2'd0;
  localparam logic [1:0] REG_BASE_INCREMENT = 2'd1;
  localparam logic [1:0] REG_COEFF_CURRENT  = 2'd2;
  localparam logic [1:0] REG_COEFF_PREVIOUS = 2'd3;

  localparam logic [LEN_W-1:0]    RST_LOOP_LENGTH    = 11'd0;
  localparam logic [INC_W-1:0]    RST_BASE_INCREMENT = 18'd65536;
  localparam logic [SAMPLE_W-1:0] RST_COEFF          = 16'sd16384;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_INC  = 8'b0000_0010,
    S_ADV  = 8'b0000_0100,
    S_RD   = 8'b0000_1000,
    S_FMUL = 8'b0001_0000,
    S_WR   = 8'b0010_0000,
    S_IMUL = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

  function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
    logic signed [15:0] r;
    if (v > 24'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -24'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

### sv/pswg_ram.sv
module pswg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/pswg_filter.sv
module pswg_filter (
  input  logic                                  clk,
  input  logic                                  load,
  input  logic signed [pswg_pkg::SAMPLE_W-1:0]  x_cur,
  input  logic signed [pswg_pkg::SAMPLE_W-1:0]  x_prev,
  input  logic signed [pswg_pkg::SAMPLE_W-1:0]  b_cur,
  input  logic signed [pswg_pkg::SAMPLE_W-1:0]  b_prev,
  output logic signed [pswg_pkg::SAMPLE_W-1:0]  y
);
  import pswg_pkg::*;

  logic signed [31:0] p_cur_r;
  logic signed [31:0] p_prev_r;
  logic signed [32:0] acc;
  logic signed [17:0] acc_sh;

  always_ff @(posedge clk) begin
    if (load) begin
      p_cur_r  <= x_cur * b_cur;
      p_prev_r <= x_prev * b_prev;
    end
  end

  // floor shift by 15 is the upper slice of the sum
  assign acc    = {p_cur_r[31], p_cur_r} + {p_prev_r[31], p_prev_r};
  assign acc_sh = acc[32:15];
  assign y      = sat16({{6{acc_sh[17]}}, acc_sh});

endmodule

### sv/plucked_string_waveguide.sv
// Plucked-string voice: a circular delay line in one single-port-write,
// registered-read RAM, read at a fractional rate. Load and restart requests
// are handled in the idle state. A step request runs increment, advance, N
// advances, interpolation and output, where N (0 to MAX_ADVANCES) is the
// number of whole phase units crossed: each advance is a read, a registered
// loop-filter multiply and a write-back on the delay RAM, one after another.
// A zero loop length skips to output. A new request is taken while a finished
// sample waits; a step then holds at its end until the output register is free.
`include "plucked_string_waveguide_macros.svh"

module plucked_string_waveguide #(
  parameter int MAX_LOOP     = pswg_pkg::PSWG_MAX_LOOP,
  parameter int MAX_ADVANCES = pswg_pkg::PSWG_MAX_ADVANCES
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0]                            in_cmd,
  input  logic [pswg_pkg::IDX_W-1:0]            in_load_index,
  input  logic signed [pswg_pkg::SAMPLE_W-1:0]  in_load_value,
  input  logic [pswg_pkg::RATE_W-1:0]           in_rate_mod,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [pswg_pkg::SAMPLE_W-1:0]  out_sample_out,
  input  logic                                  cfg_we,
  input  logic [1:0]                            cfg_index,
  input  logic [pswg_pkg::CFG_W-1:0]            cfg_wdata
);
  import pswg_pkg::*;

  localparam int AW    = $clog2(MAX_LOOP);
  localparam int LW_M  = $clog2(MAX_LOOP + 1);
  localparam int LW    = (LW_M > LEN_W) ? LW_M : LEN_W;
  localparam int ADVW  = $clog2(MAX_ADVANCES + 1);
  localparam int TW    = FRAC_W + ADVW;
  localparam int PRODW = INC_W + RATE_W;
  localparam int RAWW  = PRODW - 12;
  localparam int CW    = (TW > RAWW) ? TW : RAWW;
  localparam logic [CW-1:0] INC_LIMIT = CW'((MAX_ADVANCES * 65536) - 1);
  localparam logic [LW-1:0] LEN_MAX   = LW'(MAX_LOOP);

  logic [LEN_W-1:0]           loop_length_r;
  logic [INC_W-1:0]           base_increment_r;
  logic signed [SAMPLE_W-1:0] coeff_current_r;
  logic signed [SAMPLE_W-1:0] coeff_previous_r;

  state_t state_r, state_nxt;

  logic [RATE_W-1:0]          rate_r;
  logic [PRODW-1:0]           prod_r;
  logic [ADVW-1:0]            adv_cnt_r;
  logic [FRAC_W-1:0]          phase_r;
  logic [AW-1:0]              read_pos_r;
  logic [AW-1:0]              pos_r;
  logic signed [SAMPLE_W-1:0] prev_tap_r;
  logic signed [SAMPLE_W-1:0] interp_start_r;
  logic signed [SAMPLE_W-1:0] interp_end_r;
  logic signed [33:0]         iprod_r;
  logic                       zero_out_r;
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;

  logic                       in_acc;
  logic [LW-1:0]              len_ext;
  logic [LW-1:0]              len_eff;
  logic                       idx_ok;
  logic [CW-1:0]              inc_raw;
  logic [TW-1:0]              inc_sat;
  logic [TW-1:0]              total;
  logic [AW-1:0]              pos_fix;
  logic [LW-1:0]              pos_inc;
  logic [AW-1:0]              pos_next;
  logic                       out_free;
  logic signed [16:0]         diff;
  logic signed [16:0]         phase_s;
  logic signed [23:0]         y_ext;

  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [SAMPLE_W-1:0]        ram_wdata;
  logic                       ram_re;
  logic [SAMPLE_W-1:0]        ram_rdata;
  logic signed [SAMPLE_W-1:0] filt_y;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign len_ext = LW'(loop_length_r);
  assign len_eff = (len_ext > LEN_MAX) ? LEN_MAX : len_ext;
  assign idx_ok  = LW'(in_load_index) < LEN_MAX;

  assign inc_raw = CW'(prod_r[PRODW-1:12]);
  assign inc_sat = (inc_raw > INC_LIMIT) ? TW'(INC_LIMIT) : TW'(inc_raw);
  assign total   = TW'(phase_r) + inc_sat;

  assign pos_fix  = (LW'(read_pos_r) >= len_eff) ? '0 : read_pos_r;
  assign pos_inc  = LW'(pos_r) + LW'(1);
  assign pos_next = (pos_inc >= len_eff) ? '0 : AW'(pos_inc);

  assign diff    = {interp_end_r[15], interp_end_r} - {interp_start_r[15], interp_start_r};
  assign phase_s = {1'b0, phase_r};
  assign y_ext   = {{8{interp_start_r[15]}}, interp_start_r}
                 + {{6{iprod_r[33]}}, iprod_r[33:16]};

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loop_length_r    <= RST_LOOP_LENGTH;
      base_increment_r <= RST_BASE_INCREMENT;
      coeff_current_r  <= RST_COEFF;
      coeff_previous_r <= RST_COEFF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LOOP_LENGTH:    loop_length_r    <= cfg_wdata[LEN_W-1:0];
        REG_BASE_INCREMENT: base_increment_r <= cfg_wdata[INC_W-1:0];
        REG_COEFF_CURRENT:  coeff_current_r  <= cfg_wdata[SAMPLE_W-1:0];
        REG_COEFF_PREVIOUS: coeff_previous_r <= cfg_wdata[SAMPLE_W-1:0];
        default:            loop_length_r    <= loop_length_r;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && in_cmd == CMD_STEP) begin
          state_nxt = (len_eff == '0) ? S_OUT : S_INC;
        end
      end
      S_INC:  state_nxt = S_ADV;
      S_ADV:  state_nxt = (total[TW-1:FRAC_W] == '0) ? S_IMUL : S_RD;
      S_RD:   state_nxt = S_FMUL;
      S_FMUL: state_nxt = S_WR;
      S_WR:   state_nxt = (adv_cnt_r == ADVW'(1)) ? S_IMUL : S_RD;
      S_IMUL: state_nxt = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      adv_cnt_r      <= '0;
      phase_r        <= '0;
      read_pos_r     <= '0;
      prev_tap_r     <= '0;
      interp_start_r <= '0;
      interp_end_r   <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc && in_cmd == CMD_RESTART) begin
        phase_r        <= '0;
        read_pos_r     <= '0;
        interp_start_r <= prev_tap_r;
        interp_end_r   <= prev_tap_r;
      end
      if (state_r == S_ADV) begin
        adv_cnt_r <= total[TW-1:FRAC_W];
        phase_r   <= total[FRAC_W-1:0];
      end
      if (state_r == S_FMUL) begin
        interp_start_r <= prev_tap_r;
        interp_end_r   <= ram_rdata;
        prev_tap_r     <= ram_rdata;
      end
      if (state_r == S_WR) begin
        read_pos_r <= pos_next;
        adv_cnt_r  <= adv_cnt_r - ADVW'(1);
      end
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rate_r     <= in_rate_mod;
      zero_out_r <= (len_eff == '0);
    end
    if (state_r == S_INC) begin
      prod_r <= PRODW'(base_increment_r) * PRODW'(rate_r);
    end
    if (state_r == S_RD) begin
      pos_r <= pos_fix;
    end
    if (state_r == S_IMUL) begin
      iprod_r <= phase_s * diff;
    end
    if (state_r == S_OUT && out_free) begin
      out_sample_r <= zero_out_r ? '0 : sat16(y_ext);
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pos_r;
    ram_wdata = filt_y;
    if (state_r == S_WR) begin
      ram_we = 1'b1;
    end else if (in_acc && in_cmd == CMD_LOAD && idx_ok) begin
      ram_we    = 1'b1;
      ram_waddr = AW'(in_load_index);
      ram_wdata = in_load_value;
    end
  end

  assign ram_re = (state_r == S_RD);

  pswg_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_LOOP)
  ) u_delay (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (pos_fix),
    .rdata (ram_rdata)
  );

  pswg_filter u_filter (
    .clk    (clk),
    .load   (state_r == S_FMUL),
    .x_cur  (ram_rdata),
    .x_prev (prev_tap_r),
    .b_cur  (coeff_current_r),
    .b_prev (coeff_previous_r),
    .y      (filt_y)
  );

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

  `PSWG_ASSERT_IMP(a_out_from_final, $rose(out_valid_r), $past(state_r == S_OUT))
  `PSWG_ASSERT_IMP(a_read_has_work, (state_r == S_RD), (adv_cnt_r != '0))
  `PSWG_ASSERT_NXT(a_pos_in_loop, (state_r == S_WR), (LW'(read_pos_r) < len_eff))
  `PSWG_ASSERT_IMP(a_write_slots, ram_we, (state_r == S_IDLE || state_r == S_WR))

endmodule
